/* sv/bgda_pkg.sv */
// Package: shared widths, codes, sequencer states and divider transfer types.
package bgda_pkg;

    localparam int MODE_W    = 1;
    localparam int GEN_W     = 3;
    localparam int RATE_W    = 25;
    localparam int CLK_W     = 26;
    localparam int DIVF_W    = 12;
    localparam int COUNT_W   = 8;
    localparam int SETTING_W = DIVF_W + 1;
    // clk / rate with rate >= RATE_MIN stays below 2^18
    localparam int DIV_W     = 18;
    localparam int ERR_W     = 32;
    localparam int PRE_SH    = 4;
    localparam int STEP_W    = $clog2(CLK_W);

    localparam logic [RATE_W-1:0]  RATE_MIN  = RATE_W'(503);
    localparam logic [RATE_W-1:0]  RATE_MAX  = RATE_W'(25000000);
    localparam logic [CLK_W-1:0]   CLK_RESET = CLK_W'(25000000);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_CLAIM   = 1'b0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 1'b1;

    // register index, taken from paddr bit 2
    localparam logic REG_CLOCK_HZ = 1'b0;

    typedef logic [SETTING_W-1:0] t_setting;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_Q0,
        ST_SCALE,
        ST_Q1,
        ST_Q2,
        ST_PICK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [CLK_W-1:0]  dividend;
        logic [RATE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [CLK_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* sv/bgda_if.sv */
// Interfaces: request and response channels with valid/ready handshake.
interface bgda_in_if;
    import bgda_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [GEN_W-1:0]  generator;
    logic [RATE_W-1:0] rate_bps;

    modport source (output valid, mode, generator, rate_bps, input ready);
    modport sink   (input valid, mode, generator, rate_bps, output ready);
endinterface

interface bgda_out_if;
    import bgda_pkg::*;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [CLK_W-1:0]   achieved_rate;
    logic [DIVF_W-1:0]  divider_field;
    logic               prescale_16;
    logic               start_generator;
    logic               stop_generator;
    logic [COUNT_W-1:0] user_count;

    modport source (output valid, ok, achieved_rate, divider_field, prescale_16,
                    start_generator, stop_generator, user_count, input ready);
    modport sink   (input valid, ok, achieved_rate, divider_field, prescale_16,
                    start_generator, stop_generator, user_count, output ready);
endinterface

/* sv/bgda_div.sv */
// Shared restoring divider: one quotient bit per cycle.
module bgda_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bgda_pkg::t_div_req i_req,
    output bgda_pkg::t_div_rsp o_rsp
);
    import bgda_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CLK_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_den;
    logic [CLK_W-1:0]  r_quo;

    logic [RATE_W:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_quo[CLK_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            // quotient bits shift in as dividend bits shift out
            r_rem <= ge ? RATE_W'(trial - {1'b0, r_den}) : trial[RATE_W-1:0];
            r_quo <= {r_quo[CLK_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* sv/baud_generator_divisor_allocator_unit.sv */
// Top level: baud generator divisor calculation and shared-generator allocation.
//
//  channel   dir  transfer when            payload
//  i_req     in   valid & ready            mode, generator, rate_bps
//  o_rsp     out  valid & ready            ok, achieved_rate, divider_field,
//                                          prescale_16, start/stop_generator,
//                                          user_count
//  APB       in   psel&penable&pwrite      system_clock_hz at byte address 0
//
//  Steps: a full claim runs three divider passes (start, 26 quotient bits, done)
//  plus accept, check, scale, pick, finish; two passes when divisor+1 does not fit,
//  one for an oversize divisor or clock below rate, none for releases, bad generators
//  and out-of-range rates.
//  Reset: synchronous, active low; clears counts, sequencer, output valid; clock 25 MHz.
//  Stalls: i_req.ready only in idle; a result waits in finish while o_rsp is still full.
module baud_generator_divisor_allocator_unit #(
    parameter int MAX_DIVISOR    = 4096,
    parameter int NUM_GENERATORS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bgda_in_if.sink     i_req,
    bgda_out_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bgda_pkg::*;

    localparam int GEN_IDX_W = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
    localparam logic [GEN_W:0]   NUM_GEN_L = (GEN_W + 1)'(NUM_GENERATORS);
    localparam logic [DIV_W-1:0] MAX_DIV_L = DIV_W'(MAX_DIVISOR);

    // ---------------- configuration register ----------------
    logic [CLK_W-1:0] r_clk_hz;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= CLK_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_CLOCK_HZ) begin
            r_clk_hz <= pwdata[CLK_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CLOCK_HZ) ? 32'(r_clk_hz) : '0;

    // ---------------- item registers ----------------
    t_state             r_state, n_state;
    logic [MODE_W-1:0]  r_mode;
    logic [GEN_W-1:0]   r_gen;
    logic [RATE_W-1:0]  r_rate;
    logic               r_refuse;   // range or divisor-too-large refusal
    logic [DIV_W-1:0]   r_div;      // plain candidate, then the chosen divisor
    logic               r_pre;
    logic [DIV_W-1:0]   r_try;      // divisor-plus-one candidate
    logic               r_pre2;
    logic               r_try_ok;   // candidate two fits after prescale
    logic [CLK_W-1:0]   r_ach;
    logic [CLK_W-1:0]   r_q2;

    // generator state
    logic [COUNT_W-1:0] r_counts   [NUM_GENERATORS];
    t_setting           r_settings [NUM_GENERATORS];

    // output register
    logic               r_out_valid;
    logic               r_out_ok;
    logic [CLK_W-1:0]   r_out_ach;
    logic [DIVF_W-1:0]  r_out_divf;
    logic               r_out_pre;
    logic               r_out_start;
    logic               r_out_stop;
    logic [COUNT_W-1:0] r_out_users;

    t_div_req div_req;
    t_div_rsp div_rsp;

    bgda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------- request checks ----------------
    logic                 gen_ok;
    logic                 rate_bad;
    logic [GEN_IDX_W-1:0] gidx;

    assign gen_ok   = {1'b0, r_gen} < NUM_GEN_L;
    assign rate_bad = (r_rate < RATE_MIN) || (r_rate > RATE_MAX);
    assign gidx     = r_gen[GEN_IDX_W-1:0];

    // ---------------- scaling of the first quotient ----------------
    logic [DIV_W-1:0] q0;
    logic [DIV_W-1:0] try_raw;
    logic             sc_pre, sc_pre2;
    logic [DIV_W-1:0] sc_div, sc_try;

    assign q0      = div_rsp.quotient[DIV_W-1:0];
    assign try_raw = q0 + 1'b1;
    assign sc_pre2 = try_raw > MAX_DIV_L;
    assign sc_try  = sc_pre2 ? (try_raw >> PRE_SH) : try_raw;
    assign sc_pre  = q0 > MAX_DIV_L;
    assign sc_div  = sc_pre ? (q0 >> PRE_SH) : q0;

    // ---------------- error compare (32-bit wrapping) ----------------
    logic [ERR_W-1:0] err1, err2;
    logic             take_try;

    assign err1     = ERR_W'(r_ach) - ERR_W'(r_rate);
    assign err2     = ERR_W'(r_rate) - ERR_W'(r_q2);
    assign take_try = r_try_ok && (err2 < err1);

    // ---------------- next state ----------------
    logic slot_free;
    assign slot_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!gen_ok || r_mode == MODE_RELEASE || rate_bad) n_state = ST_FINISH;
                else n_state = ST_Q0;
            end
            ST_Q0: begin
                if (div_rsp.done) n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (sc_div > MAX_DIV_L || q0 == '0) n_state = ST_FINISH;
                else n_state = ST_Q1;
            end
            ST_Q1: begin
                if (div_rsp.done) n_state = r_try_ok ? ST_Q2 : ST_PICK;
            end
            ST_Q2: begin
                if (div_rsp.done) n_state = ST_PICK;
            end
            ST_PICK: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    logic commit;

    always_comb begin
        i_req.ready     = 1'b0;
        commit          = 1'b0;
        div_req.start   = 1'b0;
        div_req.dividend = r_clk_hz;
        div_req.divisor  = r_rate;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_CHECK: begin
                div_req.start = gen_ok && r_mode == MODE_CLAIM && !rate_bad;
            end
            ST_SCALE: begin
                div_req.start    = !(sc_div > MAX_DIV_L) && q0 != '0;
                div_req.dividend = sc_pre ? (r_clk_hz >> PRE_SH) : r_clk_hz;
                div_req.divisor  = RATE_W'(sc_div);
            end
            ST_Q1: begin
                div_req.start    = div_rsp.done && r_try_ok;
                div_req.dividend = r_pre2 ? (r_clk_hz >> PRE_SH) : r_clk_hz;
                div_req.divisor  = RATE_W'(r_try);
            end
            ST_FINISH: begin
                commit = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    r_mode   <= i_req.mode;
                    r_gen    <= i_req.generator;
                    r_rate   <= i_req.rate_bps;
                    r_refuse <= 1'b0;
                end
            end
            ST_CHECK: begin
                r_refuse <= rate_bad;
            end
            ST_SCALE: begin
                r_try    <= sc_try;
                r_pre2   <= sc_pre2;
                r_try_ok <= !(sc_try > MAX_DIV_L);
                if (sc_div > MAX_DIV_L) begin
                    r_refuse <= 1'b1;
                end else if (q0 == '0) begin
                    // clock below rate: divisor one, rate equals clock
                    r_div <= sc_try;
                    r_pre <= sc_pre2;
                    r_ach <= r_clk_hz;
                end else begin
                    r_div <= sc_div;
                    r_pre <= sc_pre;
                end
            end
            ST_Q1: begin
                if (div_rsp.done) r_ach <= div_rsp.quotient;
            end
            ST_Q2: begin
                if (div_rsp.done) r_q2 <= div_rsp.quotient;
            end
            ST_PICK: begin
                if (take_try) begin
                    r_div <= r_try;
                    r_pre <= r_pre2;
                    r_ach <= r_q2;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- allocation decision ----------------
    logic [COUNT_W-1:0] cnt;
    t_setting           setting;
    logic [DIV_W-1:0]   div_m1;
    logic               f_ok, f_start, f_stop, f_write_cnt, f_program;
    logic [COUNT_W-1:0] f_users;

    assign cnt     = r_counts[gidx];
    assign div_m1  = r_div - 1'b1;
    assign setting = {r_pre, div_m1[DIVF_W-1:0]};

    always_comb begin
        f_ok        = 1'b0;
        f_start     = 1'b0;
        f_stop      = 1'b0;
        f_write_cnt = 1'b0;
        f_program   = 1'b0;
        f_users     = '0;
        if (gen_ok) begin
            if (r_mode == MODE_RELEASE) begin
                if (cnt != '0) begin
                    f_ok        = 1'b1;
                    f_users     = cnt - 1'b1;
                    f_stop      = cnt == COUNT_W'(1);
                    f_write_cnt = 1'b1;
                end
            end else if (r_refuse) begin
                f_users = cnt;
            end else if (cnt == '0) begin
                // first user programs and starts the generator
                f_ok        = 1'b1;
                f_start     = 1'b1;
                f_users     = COUNT_W'(1);
                f_write_cnt = 1'b1;
                f_program   = 1'b1;
            end else if (r_settings[gidx] != setting || cnt == COUNT_MAX) begin
                f_users = cnt;
            end else begin
                f_ok        = 1'b1;
                f_users     = cnt + 1'b1;
                f_write_cnt = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '{default: '0};
        end else if (commit && f_write_cnt) begin
            r_counts[gidx] <= f_users;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && f_program) r_settings[gidx] <= setting;
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_ok    <= f_ok;
            r_out_ach   <= (f_ok && r_mode == MODE_CLAIM) ? r_ach : '0;
            r_out_divf  <= (f_ok && r_mode == MODE_CLAIM) ? div_m1[DIVF_W-1:0] : '0;
            r_out_pre   <= f_ok && r_mode == MODE_CLAIM && r_pre;
            r_out_start <= f_start;
            r_out_stop  <= f_stop;
            r_out_users <= f_users;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.ok              = r_out_ok;
    assign o_rsp.achieved_rate   = r_out_ach;
    assign o_rsp.divider_field   = r_out_divf;
    assign o_rsp.prescale_16     = r_out_pre;
    assign o_rsp.start_generator = r_out_start;
    assign o_rsp.stop_generator  = r_out_stop;
    assign o_rsp.user_count      = r_out_users;

    // ---------------- assertions ----------------
    a_start_first_user: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.start_generator |-> o_rsp.ok && o_rsp.user_count == 8'd1)
        else $error("generator start without a first user");

    a_stop_last_user: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.stop_generator |-> o_rsp.ok && o_rsp.user_count == '0)
        else $error("generator stop while users remain");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_Q0 || r_state == ST_Q1 || r_state == ST_Q2))
        else $error("divider finished outside a wait state");

    a_commit_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid && r_state == ST_IDLE)
        else $error("result not held after commit");

endmodule

/* test/tb_top.sv */
// Testbench: random and directed claim/release traffic against a predictor of the allocator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bgda_pkg::*;

    // Block configuration as instantiated below
    localparam int MAX_DIV = 4096;
    localparam int NUM_GEN = 4;

    localparam logic [31:0] PRESCALE    = 32'd16;
    localparam logic [2:0]  CLOCK_ADDR  = {REG_CLOCK_HZ, 2'b00};
    // Watchdog limit on simulated cycles for the whole run
    localparam int          CYCLE_LIMIT = 1_000_000;

    // Expected response of one request
    typedef struct packed {
        logic               ok;
        logic [CLK_W-1:0]   achieved_rate;
        logic [DIVF_W-1:0]  divider_field;
        logic               prescale_16;
        logic               start_generator;
        logic               stop_generator;
        logic [COUNT_W-1:0] user_count;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bgda_in_if  req_if ();
    bgda_out_if rsp_if ();

    baud_generator_divisor_allocator_unit #(
        .MAX_DIVISOR    (MAX_DIV),
        .NUM_GENERATORS (NUM_GEN)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: clock register, use counts and programmed settings
    logic [CLK_W-1:0]   clock_hz = CLK_RESET;
    logic [COUNT_W-1:0] users [NUM_GEN] = '{default: '0};
    t_setting           settings [NUM_GEN] = '{default: '0};

    t_grant pending_grants [$];
    int     mismatches  = 0;
    int     cycles      = 0;
    int     hold_cycles = 0;   // receiver back-pressure stretch, counted down per cycle
    bit     steady      = 0;   // no idling on either side while set

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Expected response for one accepted request; advances the predictor state.
    function automatic t_grant predict_grant(input logic [MODE_W-1:0] mode,
                                             input logic [GEN_W-1:0]  gen,
                                             input logic [RATE_W-1:0] rate);
        t_grant      g_out;
        logic [31:0] clk, quo, nxt, pre, nxt_pre, err_plain, err_next, achieved;
        t_setting    setting;
        int          idx;
        g_out = '0;
        idx   = int'(gen);
        if (idx >= NUM_GEN) return g_out;

        if (mode == MODE_RELEASE) begin
            if (users[idx] == '0) return g_out;
            users[idx]--;
            g_out.ok             = 1'b1;
            g_out.stop_generator = (users[idx] == '0);
            g_out.user_count     = users[idx];
            return g_out;
        end

        // refusals below still report the current count
        g_out.user_count = users[idx];
        if (rate < RATE_MIN || rate > RATE_MAX) return g_out;

        clk     = 32'(clock_hz);
        quo     = clk / 32'(rate);
        pre     = 32'd1;
        nxt     = quo + 32'd1;
        nxt_pre = 32'd1;
        if (nxt > MAX_DIV) begin
            nxt     = nxt >> PRE_SH;
            nxt_pre = PRESCALE;
        end
        if (quo > MAX_DIV) begin
            quo = quo >> PRE_SH;
            pre = PRESCALE;
        end
        if (quo > MAX_DIV) return g_out;

        if (quo == 32'd0) begin
            // clock below rate: divide by one
            quo = nxt;
            pre = nxt_pre;
        end else begin
            // 32-bit wrapping errors, compared unsigned
            err_plain = clk / pre / quo - 32'(rate);
            err_next  = 32'(rate) - clk / nxt_pre / nxt;
            if (nxt > MAX_DIV) err_next = err_plain;
            if (err_next < err_plain) begin
                quo = nxt;
                pre = nxt_pre;
            end
        end

        setting  = {pre == PRESCALE, DIVF_W'(quo - 32'd1)};
        achieved = clk / pre / quo;

        if (users[idx] == '0) begin
            settings[idx]         = setting;
            users[idx]            = COUNT_W'(1);
            g_out.start_generator = 1'b1;
        end else if (settings[idx] != setting || users[idx] == COUNT_MAX) begin
            return g_out;
        end else begin
            users[idx]++;
        end
        g_out.ok            = 1'b1;
        g_out.achieved_rate = CLK_W'(achieved);
        g_out.divider_field = setting[DIVF_W-1:0];
        g_out.prescale_16   = setting[DIVF_W];
        g_out.user_count    = users[idx];
        return g_out;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Response checker: every transfer on o_rsp against the oldest expectation
    always @(posedge i_clk) begin
        t_grant want;
        if (rsp_if.valid && rsp_if.ready) begin
            if (pending_grants.size() == 0) begin
                $error("response transfer with nothing expected");
                mismatches++;
            end else begin
                want = pending_grants.pop_front();
                check_field("ok", 32'(want.ok), 32'(rsp_if.ok));
                check_field("achieved_rate", 32'(want.achieved_rate),
                            32'(rsp_if.achieved_rate));
                check_field("divider_field", 32'(want.divider_field),
                            32'(rsp_if.divider_field));
                check_field("prescale_16", 32'(want.prescale_16), 32'(rsp_if.prescale_16));
                check_field("start_generator", 32'(want.start_generator),
                            32'(rsp_if.start_generator));
                check_field("stop_generator", 32'(want.stop_generator),
                            32'(rsp_if.stop_generator));
                check_field("user_count", 32'(want.user_count), 32'(rsp_if.user_count));
            end
        end
    end

    // Receiver: random stalls, a calm mode, and long hold-offs on request
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    // One request transfer; the expectation is queued at the accepting edge.
    // valid stays high into the next call unless that call idles first.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [GEN_W-1:0]  gen,
                                input logic [RATE_W-1:0] rate);
        if (!steady && $urandom_range(99) < 15) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.mode      <= mode;
        req_if.generator <= gen;
        req_if.rate_bps  <= rate;
        do @(posedge i_clk); while (!req_if.ready);
        pending_grants.push_back(predict_grant(mode, gen, rate));
    endtask

    // Drop valid and let every outstanding response drain
    task automatic drain_responses();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of the clock register while idle, then read it back
    task automatic write_clock_hz(input logic [CLK_W-1:0] hz);
        logic [31:0] got;
        drain_responses();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CLOCK_ADDR;
        pwdata  <= 32'(hz);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        clock_hz = hz;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        check_field("system_clock_hz", 32'(hz), got);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Release every generator down to zero users
    task automatic release_all();
        for (int g = 0; g < NUM_GEN; g++) begin
            while (users[g] != '0) send_request(MODE_RELEASE, GEN_W'(g), RATE_W'($urandom));
        end
    endtask

    function automatic logic [RATE_W-1:0] standard_rate(input int sel);
        case (sel)
            0:       return RATE_W'(1200);
            1:       return RATE_W'(2400);
            2:       return RATE_W'(9600);
            3:       return RATE_W'(19200);
            4:       return RATE_W'(38400);
            5:       return RATE_W'(57600);
            6:       return RATE_W'(115200);
            7:       return RATE_W'(230400);
            8:       return RATE_W'(460800);
            default: return RATE_W'(921600);
        endcase
    endfunction

    // Rate bounds at the reset clock, including the divide-by-one top rate
    task automatic test_rate_limits();
        send_request(MODE_CLAIM, 3'd0, '0);
        send_request(MODE_CLAIM, 3'd0, RATE_MIN - 1'b1);
        send_request(MODE_CLAIM, 3'd0, RATE_MIN);
        send_request(MODE_CLAIM, 3'd1, RATE_MAX);
        send_request(MODE_CLAIM, 3'd1, RATE_MAX + 1'b1);
        send_request(MODE_CLAIM, 3'd1, '1);
        send_request(MODE_RELEASE, 3'd0, '0);
        send_request(MODE_RELEASE, 3'd1, '1);
    endtask

    // Out-of-range generator indexes and release of an unused generator
    task automatic test_bad_generator();
        send_request(MODE_CLAIM, 3'd4, RATE_W'(115200));
        send_request(MODE_CLAIM, 3'd7, RATE_W'(9600));
        send_request(MODE_RELEASE, 3'd5, '0);
        send_request(MODE_RELEASE, 3'd7, '0);
        send_request(MODE_RELEASE, 3'd3, '0);
    endtask

    // Shared user with same setting, mismatching claim, release to zero
    task automatic test_setting_match();
        send_request(MODE_CLAIM, 3'd3, RATE_W'(9600));
        send_request(MODE_CLAIM, 3'd3, RATE_W'(9600));
        send_request(MODE_CLAIM, 3'd3, RATE_W'(19200));
        send_request(MODE_RELEASE, 3'd3, '0);
        send_request(MODE_RELEASE, 3'd3, '0);
        send_request(MODE_RELEASE, 3'd3, '0);
    endtask

    // Divisor edges: overflow after prescale, top count, out-of-range next divisor, slow clock
    task automatic test_divisor_limits();
        write_clock_hz(CLK_W'(26'h3FF_FFFF));
        send_request(MODE_CLAIM, 3'd0, RATE_MIN);          // too large even after /16
        send_request(MODE_CLAIM, 3'd0, RATE_W'(16384));    // rounds up to full count
        send_request(MODE_RELEASE, 3'd0, '0);
        write_clock_hz(CLK_W'(65551000));
        send_request(MODE_CLAIM, 3'd1, RATE_W'(1000));     // next divisor out of range
        send_request(MODE_RELEASE, 3'd1, '0);
        write_clock_hz(CLK_W'(1000));
        send_request(MODE_CLAIM, 3'd2, RATE_W'(5000));     // clock below rate
        send_request(MODE_RELEASE, 3'd2, '0);
    endtask

    // Fill one generator to the count limit, overflow it, then empty it
    task automatic test_count_full();
        write_clock_hz(CLK_RESET);
        release_all();
        repeat (int'(COUNT_MAX)) send_request(MODE_CLAIM, 3'd2, RATE_W'(57600));
        send_request(MODE_CLAIM, 3'd2, RATE_W'(57600));
        release_all();
        send_request(MODE_RELEASE, 3'd2, '0);
    endtask

    // One random request, weighted toward a small rate pool so users share settings
    task automatic send_random(input logic [RATE_W-1:0] pool [4]);
        logic [GEN_W-1:0]  gen;
        logic [MODE_W-1:0] mode;
        logic [RATE_W-1:0] rate;
        int                pick;
        gen  = ($urandom_range(99) < 90) ? GEN_W'($urandom_range(NUM_GEN - 1))
                                         : GEN_W'($urandom_range(7));
        mode = ($urandom_range(99) < 40) ? MODE_RELEASE : MODE_CLAIM;
        pick = $urandom_range(99);
        if (pick < 70) begin
            rate = pool[$urandom_range(3)];
        end else if (pick < 80) begin
            rate = RATE_W'($urandom_range(RATE_MAX, RATE_MIN));
        end else if (pick < 90) begin
            rate = RATE_W'($urandom);
        end else begin
            case ($urandom_range(3))
                0:       rate = RATE_MIN - 1'b1;
                1:       rate = RATE_MIN;
                2:       rate = RATE_MAX;
                default: rate = RATE_MAX + 1'b1;
            endcase
        end
        send_request(mode, gen, rate);
    endtask

    // Random phases over several clock settings, one calm and one back-pressured
    task automatic test_random_traffic();
        logic [CLK_W-1:0]  clocks [6];
        logic [RATE_W-1:0] pool [4];
        clocks = '{CLK_RESET, CLK_W'(1), CLK_W'(26'h3FF_FFFF), CLK_W'(14745600),
                   CLK_W'(48000000), CLK_W'($urandom)};
        for (int ph = 0; ph < 6; ph++) begin
            write_clock_hz(clocks[ph]);
            release_all();
            for (int k = 0; k < 4; k++) pool[k] = standard_rate($urandom_range(9));
            steady = (ph == 3);
            // long output hold-off: the block fills and stalls its input
            if (ph == 1) hold_cycles = 400;
            repeat (85) send_random(pool);
        end
        steady = 0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_CLAIM;
        req_if.generator = '0;
        req_if.rate_bps  = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_rate_limits();
        test_bad_generator();
        test_setting_match();
        test_divisor_limits();
        test_count_full();
        test_random_traffic();

        drain_responses();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
